### rtl/lscd_pkg.sv
// Shared types, constants and helpers for the level-set contour distance block.
// No dependencies; every other rtl file refers to this package by scoped names.
`timescale 1ns / 1ps

package lscd_pkg;

    localparam int IN_W   = 32;           // width of every input field
    localparam int CW     = 32;           // coordinate bits in use
    localparam int FW     = 24;           // fraction bits of the fixed-point format
    localparam int EPS_W  = 24;           // tolerance register width
    localparam int DIST_W = 64;           // squared distance output width
    localparam int QD     = 2;            // queue depth between front and back
    localparam int QAW    = $clog2(QD);
    localparam int XL     = FW + 3;       // crossing unit pipeline length
    localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(16);

    typedef struct packed {
        logic signed [IN_W-1:0] ax;
        logic signed [IN_W-1:0] ay;
        logic signed [IN_W-1:0] bx;
        logic signed [IN_W-1:0] by_coord;
        logic signed [IN_W-1:0] cx;
        logic signed [IN_W-1:0] cy;
        logic signed [IN_W-1:0] val_a;
        logic signed [IN_W-1:0] val_b;
        logic signed [IN_W-1:0] val_c;
        logic signed [IN_W-1:0] qx;
        logic signed [IN_W-1:0] qy;
    } t_in_item;

    typedef struct packed {
        logic [DIST_W-1:0] dist_sq;
        logic              endpoint_hit;
        logic              flat_error;
    } t_out_item;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
    } t_pt;

    // Edge from p (value u) to r (value v) whose zero crossing is wanted.
    typedef struct packed {
        t_pt                  p;
        t_pt                  r;
        logic signed [CW-1:0] u;
        logic signed [CW-1:0] v;
    } t_xing_req;

    typedef struct packed {
        logic use_x1;     // segment start comes from crossing unit 1
        logic use_x2;     // segment end comes from crossing unit 2
        logic is_point;   // segment is the start vertex alone
        logic flat;       // all three values zero
    } t_job_ctl;

    typedef struct packed {
        t_pt      s1;
        t_pt      s2;
        t_pt      q;
        t_job_ctl ctl;
    } t_side;

    typedef struct packed {
        t_xing_req x1;
        t_xing_req x2;
        t_side     side;
    } t_job;

    typedef enum logic [1:0] {
        PICK_S1,
        PICK_S2,
        PICK_PROJ
    } t_pick;

    typedef struct packed {
        t_pt             s1;
        t_pt             s2;
        t_pt             q;
        logic [CW-1:0]   awx;
        logic [CW-1:0]   awy;
        logic            swx;
        logic            swy;
        logic            is_point;
        t_pick           pick;
        logic            flat;
    } t_seg_side;

    function automatic logic signed [CW:0] ext(input logic signed [CW-1:0] a);
        return {a[CW-1], a};
    endfunction

    // Magnitude of a difference of two coordinates; it always fits CW bits.
    function automatic logic [CW-1:0] abs_d(input logic signed [CW:0] a);
        logic [CW:0] n;
        n = -a;
        return a[CW] ? n[CW-1:0] : a[CW-1:0];
    endfunction

    function automatic logic [CW-1:0] abs_v(input logic signed [CW-1:0] a);
        logic [CW-1:0] n;
        n = -a;
        return a[CW-1] ? n : a;
    endfunction

endpackage

### rtl/level_set_contour_distance.sv
// Throughput: one transaction per cycle unless i_ready stalls the output; set
// by the pipelined crossing and projection dividers, one quotient bit per stage.
// Reset: synchronous active-low i_rst_n empties the pipeline and queue and
// loads the tolerance register with 16.
`timescale 1ns / 1ps

module level_set_contour_distance (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  lscd_pkg::t_in_item         i_item,
    output logic                       o_valid,
    input  logic                       i_ready,
    output lscd_pkg::t_out_item        o_item,
    input  logic                       i_cfg_we,
    input  logic [lscd_pkg::EPS_W-1:0] i_cfg_wdata
);

    logic [lscd_pkg::EPS_W-1:0] r_eps;
    logic                       w_fv, w_fr, w_qv, w_qr;
    lscd_pkg::t_job             w_fjob, w_qjob;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps <= lscd_pkg::EPS_RESET;
        end else if (i_cfg_we) begin
            r_eps <= i_cfg_wdata;
        end
    end

    lscd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (i_item),
        .o_valid (w_fv),
        .i_ready (w_fr),
        .o_job   (w_fjob)
    );

    lscd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_fv),
        .o_ready (w_fr),
        .i_job   (w_fjob),
        .o_valid (w_qv),
        .i_ready (w_qr),
        .o_job   (w_qjob)
    );

    lscd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_eps   (r_eps),
        .i_valid (w_qv),
        .o_ready (w_qr),
        .i_job   (w_qjob),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_item  (o_item)
    );

endmodule

### rtl/lscd_front.sv
// Front stage: accepts a triangle transaction and classifies its zero isoline.
// Uses lscd_pkg for the item and job types.
`timescale 1ns / 1ps

module lscd_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  lscd_pkg::t_in_item i_item,
    output logic              o_valid,
    input  logic              i_ready,
    output lscd_pkg::t_job    o_job
);

    logic           r_v;
    lscd_pkg::t_job r_job;
    lscd_pkg::t_job n_job;

    lscd_pkg::t_pt                  w_a, w_b, w_c, w_q;
    logic signed [lscd_pkg::CW-1:0] w_va, w_vb, w_vc;
    logic                           w_za, w_zb, w_zc;

    function automatic logic opp(input logic signed [lscd_pkg::CW-1:0] u,
                                 input logic signed [lscd_pkg::CW-1:0] v);
        logic un, vn, up, vp;
        un = u[lscd_pkg::CW-1];
        vn = v[lscd_pkg::CW-1];
        up = !un && (u != '0);
        vp = !vn && (v != '0);
        return (un && vp) || (up && vn);
    endfunction

    function automatic lscd_pkg::t_xing_req mk_req(input lscd_pkg::t_pt p,
                                                   input lscd_pkg::t_pt r,
                                                   input logic signed [lscd_pkg::CW-1:0] u,
                                                   input logic signed [lscd_pkg::CW-1:0] v);
        lscd_pkg::t_xing_req q;
        q.p = p;
        q.r = r;
        q.u = u;
        q.v = v;
        return q;
    endfunction

    assign w_a.x = i_item.ax[lscd_pkg::CW-1:0];
    assign w_a.y = i_item.ay[lscd_pkg::CW-1:0];
    assign w_b.x = i_item.bx[lscd_pkg::CW-1:0];
    assign w_b.y = i_item.by_coord[lscd_pkg::CW-1:0];
    assign w_c.x = i_item.cx[lscd_pkg::CW-1:0];
    assign w_c.y = i_item.cy[lscd_pkg::CW-1:0];
    assign w_q.x = i_item.qx[lscd_pkg::CW-1:0];
    assign w_q.y = i_item.qy[lscd_pkg::CW-1:0];
    assign w_va  = i_item.val_a[lscd_pkg::CW-1:0];
    assign w_vb  = i_item.val_b[lscd_pkg::CW-1:0];
    assign w_vc  = i_item.val_c[lscd_pkg::CW-1:0];
    assign w_za  = (w_va == '0);
    assign w_zb  = (w_vb == '0);
    assign w_zc  = (w_vc == '0);

    always_comb begin
        n_job          = '0;
        n_job.x1       = mk_req(w_a, w_b, w_va, w_vb);
        n_job.x2       = mk_req(w_a, w_c, w_va, w_vc);
        n_job.side.s1  = w_a;
        n_job.side.s2  = w_b;
        n_job.side.q   = w_q;
        if (w_za && w_zb && w_zc) begin
            n_job.side.ctl.flat = 1'b1;
        end else if (w_za && w_zb) begin
            n_job.side.s1 = w_a;
            n_job.side.s2 = w_b;
        end else if (w_za && w_zc) begin
            n_job.side.s1 = w_a;
            n_job.side.s2 = w_c;
        end else if (w_zb && w_zc) begin
            n_job.side.s1 = w_b;
            n_job.side.s2 = w_c;
        end else if (w_za) begin
            n_job.side.s1 = w_a;
            n_job.x2      = mk_req(w_b, w_c, w_vb, w_vc);
            n_job.side.ctl.use_x2   = opp(w_vb, w_vc);
            n_job.side.ctl.is_point = !opp(w_vb, w_vc);
        end else if (w_zb) begin
            n_job.side.s1 = w_b;
            n_job.x2      = mk_req(w_a, w_c, w_va, w_vc);
            n_job.side.ctl.use_x2   = opp(w_va, w_vc);
            n_job.side.ctl.is_point = !opp(w_va, w_vc);
        end else if (w_zc) begin
            n_job.side.s1 = w_c;
            n_job.x2      = mk_req(w_a, w_b, w_va, w_vb);
            n_job.side.ctl.use_x2   = opp(w_va, w_vb);
            n_job.side.ctl.is_point = !opp(w_va, w_vb);
        end else begin
            // both crossings share the vertex whose sign differs from the others
            n_job.side.ctl.use_x1 = 1'b1;
            n_job.side.ctl.use_x2 = 1'b1;
            if (!opp(w_va, w_vb)) begin
                n_job.x1 = mk_req(w_c, w_b, w_vc, w_vb);
                n_job.x2 = mk_req(w_c, w_a, w_vc, w_va);
            end else if (!opp(w_va, w_vc)) begin
                n_job.x1 = mk_req(w_b, w_a, w_vb, w_va);
                n_job.x2 = mk_req(w_b, w_c, w_vb, w_vc);
            end else begin
                n_job.x1 = mk_req(w_a, w_b, w_va, w_vb);
                n_job.x2 = mk_req(w_a, w_c, w_va, w_vc);
            end
        end
    end

    assign o_ready = !r_v || i_ready;
    assign o_valid = r_v;
    assign o_job   = r_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_job <= n_job;
        end
    end

endmodule

### rtl/lscd_fifo.sv
// Short job queue between the classifying front and the arithmetic back.
// Uses lscd_pkg for the job type and depth.
`timescale 1ns / 1ps

module lscd_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  lscd_pkg::t_job i_job,
    output logic           o_valid,
    input  logic           i_ready,
    output lscd_pkg::t_job o_job
);

    lscd_pkg::t_job            r_mem [0:lscd_pkg::QD-1];
    logic [lscd_pkg::QAW-1:0]  r_wp, r_rp;
    logic [lscd_pkg::QAW:0]    r_cnt;
    logic                      w_push, w_pop;

    assign o_ready = (r_cnt != (lscd_pkg::QAW+1)'(lscd_pkg::QD));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

### rtl/lscd_xing.sv
// Edge crossing unit: pipelined restoring divide for the crossing ratio,
// then a scale and offset per coordinate. Uses lscd_pkg.
`timescale 1ns / 1ps

module lscd_xing (
    input  logic                i_clk,
    input  logic                i_en,
    input  lscd_pkg::t_xing_req i_req,
    output lscd_pkg::t_pt       o_pt
);

    logic [lscd_pkg::CW:0]          r_rem [0:lscd_pkg::FW];
    logic [lscd_pkg::CW:0]          r_den [0:lscd_pkg::FW];
    logic [lscd_pkg::FW-1:0]        r_lam [0:lscd_pkg::FW];
    logic [lscd_pkg::CW-1:0]        r_adx [0:lscd_pkg::FW];
    logic [lscd_pkg::CW-1:0]        r_ady [0:lscd_pkg::FW];
    logic                           r_sx  [0:lscd_pkg::FW];
    logic                           r_sy  [0:lscd_pkg::FW];
    lscd_pkg::t_pt                  r_base [0:lscd_pkg::FW];

    logic [lscd_pkg::CW+lscd_pkg::FW-1:0] r_tx, r_ty;
    logic                                 r_msx, r_msy;
    lscd_pkg::t_pt                        r_mbase;
    lscd_pkg::t_pt                        r_out;

    logic [lscd_pkg::CW-1:0]        w_au, w_av;
    logic signed [lscd_pkg::CW:0]   w_dx, w_dy;
    logic signed [lscd_pkg::CW:0]   n_x, n_y;

    assign w_au = lscd_pkg::abs_v(i_req.u);
    assign w_av = lscd_pkg::abs_v(i_req.v);
    assign w_dx = lscd_pkg::ext(i_req.r.x) - lscd_pkg::ext(i_req.p.x);
    assign w_dy = lscd_pkg::ext(i_req.r.y) - lscd_pkg::ext(i_req.p.y);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= {1'b0, w_au};
            r_den[0]  <= {1'b0, w_au} + {1'b0, w_av};
            r_lam[0]  <= '0;
            r_adx[0]  <= lscd_pkg::abs_d(w_dx);
            r_ady[0]  <= lscd_pkg::abs_d(w_dy);
            r_sx[0]   <= w_dx[lscd_pkg::CW];
            r_sy[0]   <= w_dy[lscd_pkg::CW];
            r_base[0] <= i_req.p;
        end
    end

    // one quotient bit per stage
    for (genvar gk = 0; gk < lscd_pkg::FW; gk++) begin : g_div
        logic [lscd_pkg::CW+1:0] n_sh;
        logic [lscd_pkg::CW+1:0] n_diff;
        logic                    n_ge;

        assign n_sh   = {r_rem[gk], 1'b0};
        assign n_diff = n_sh - {1'b0, r_den[gk]};
        assign n_ge   = (n_sh >= {1'b0, r_den[gk]});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[gk+1]  <= n_ge ? n_diff[lscd_pkg::CW:0] : n_sh[lscd_pkg::CW:0];
                r_lam[gk+1]  <= {r_lam[gk][lscd_pkg::FW-2:0], n_ge};
                r_den[gk+1]  <= r_den[gk];
                r_adx[gk+1]  <= r_adx[gk];
                r_ady[gk+1]  <= r_ady[gk];
                r_sx[gk+1]   <= r_sx[gk];
                r_sy[gk+1]   <= r_sy[gk];
                r_base[gk+1] <= r_base[gk];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tx    <= r_adx[lscd_pkg::FW] * r_lam[lscd_pkg::FW];
            r_ty    <= r_ady[lscd_pkg::FW] * r_lam[lscd_pkg::FW];
            r_msx   <= r_sx[lscd_pkg::FW];
            r_msy   <= r_sy[lscd_pkg::FW];
            r_mbase <= r_base[lscd_pkg::FW];
        end
    end

    always_comb begin
        n_x = r_msx ? lscd_pkg::ext(r_mbase.x) - {1'b0, r_tx[lscd_pkg::CW+lscd_pkg::FW-1:lscd_pkg::FW]}
                    : lscd_pkg::ext(r_mbase.x) + {1'b0, r_tx[lscd_pkg::CW+lscd_pkg::FW-1:lscd_pkg::FW]};
        n_y = r_msy ? lscd_pkg::ext(r_mbase.y) - {1'b0, r_ty[lscd_pkg::CW+lscd_pkg::FW-1:lscd_pkg::FW]}
                    : lscd_pkg::ext(r_mbase.y) + {1'b0, r_ty[lscd_pkg::CW+lscd_pkg::FW-1:lscd_pkg::FW]};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out.x <= n_x[lscd_pkg::CW-1:0];
            r_out.y <= n_y[lscd_pkg::CW-1:0];
        end
    end

    assign o_pt = r_out;

endmodule

### rtl/lscd_back.sv
// Back end: two crossing units, then the point-to-segment distance pipeline
// with its own restoring divider. Uses lscd_pkg and lscd_xing.
`timescale 1ns / 1ps

module lscd_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [lscd_pkg::EPS_W-1:0] i_eps,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  lscd_pkg::t_job            i_job,
    output logic                      o_valid,
    input  logic                      i_ready,
    output lscd_pkg::t_out_item       o_item
);

    localparam int PW = 2 * lscd_pkg::CW;

    logic w_en;

    // crossing section
    lscd_pkg::t_side r_xsb [0:lscd_pkg::XL-1];
    logic            r_xv  [0:lscd_pkg::XL-1];
    lscd_pkg::t_pt   w_x1, w_x2;

    // stage A
    logic               r_av;
    lscd_pkg::t_seg_side r_as;
    logic [lscd_pkg::CW-1:0] r_aex, r_aey;
    logic               r_asex, r_asey;
    lscd_pkg::t_pt      n_s1, n_s2;
    logic signed [lscd_pkg::CW:0] n_wx, n_wy, n_ex, n_ey;

    // stage B
    logic               r_bv;
    lscd_pkg::t_seg_side r_bs;
    logic [PW-1:0]      r_wxx, r_wyy, r_p1, r_p2;
    logic               r_n1, r_n2;

    // stage C
    logic               r_cv;
    lscd_pkg::t_seg_side r_cs;
    logic [PW:0]        r_dd, r_num;
    logic               r_neg;

    // stage D and divider
    logic               n_negf, n_small, n_beyond;
    lscd_pkg::t_pick    n_pick;
    lscd_pkg::t_seg_side n_ds;
    logic               r_dv  [0:lscd_pkg::FW];
    lscd_pkg::t_seg_side r_ds [0:lscd_pkg::FW];
    logic [PW:0]        r_rem [0:lscd_pkg::FW];
    logic [PW:0]        r_den [0:lscd_pkg::FW];
    logic [lscd_pkg::FW-1:0] r_quo [0:lscd_pkg::FW];

    // stage E
    logic               r_ev;
    lscd_pkg::t_seg_side r_es;
    logic [lscd_pkg::CW+lscd_pkg::FW-1:0] r_mx, r_my;

    // stage F
    logic               r_fv, r_fhit, r_fflat;
    logic [lscd_pkg::CW-1:0] r_fdx, r_fdy;
    logic signed [lscd_pkg::CW:0] n_xpx, n_xpy;
    lscd_pkg::t_pt      n_xp, n_pt;

    // stage G
    logic               r_gv, r_ghit, r_gflat;
    logic [PW-1:0]      r_dx2, r_dy2;

    // output
    logic               r_ov;
    lscd_pkg::t_out_item r_out;
    logic [lscd_pkg::DIST_W:0] n_sum;

    assign w_en    = !r_ov || i_ready;
    assign o_ready = w_en;

    lscd_xing u_xing1 (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_req (i_job.x1),
        .o_pt  (w_x1)
    );

    lscd_xing u_xing2 (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_req (i_job.x2),
        .o_pt  (w_x2)
    );

    // side data rides alongside the crossing units
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_xsb[0] <= i_job.side;
            for (int i = 1; i < lscd_pkg::XL; i++) begin
                r_xsb[i] <= r_xsb[i-1];
            end
        end
    end

    // stage A: pick the segment ends and form the differences
    always_comb begin
        n_s1 = r_xsb[lscd_pkg::XL-1].ctl.use_x1 ? w_x1 : r_xsb[lscd_pkg::XL-1].s1;
        n_s2 = r_xsb[lscd_pkg::XL-1].ctl.use_x2 ? w_x2 : r_xsb[lscd_pkg::XL-1].s2;
        n_wx = lscd_pkg::ext(n_s1.x) - lscd_pkg::ext(n_s2.x);
        n_wy = lscd_pkg::ext(n_s1.y) - lscd_pkg::ext(n_s2.y);
        n_ex = lscd_pkg::ext(r_xsb[lscd_pkg::XL-1].q.x) - lscd_pkg::ext(n_s2.x);
        n_ey = lscd_pkg::ext(r_xsb[lscd_pkg::XL-1].q.y) - lscd_pkg::ext(n_s2.y);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_as.s1       <= n_s1;
            r_as.s2       <= n_s2;
            r_as.q        <= r_xsb[lscd_pkg::XL-1].q;
            r_as.awx      <= lscd_pkg::abs_d(n_wx);
            r_as.awy      <= lscd_pkg::abs_d(n_wy);
            r_as.swx      <= n_wx[lscd_pkg::CW];
            r_as.swy      <= n_wy[lscd_pkg::CW];
            r_as.is_point <= r_xsb[lscd_pkg::XL-1].ctl.is_point;
            r_as.pick     <= lscd_pkg::PICK_S1;
            r_as.flat     <= r_xsb[lscd_pkg::XL-1].ctl.flat;
            r_aex         <= lscd_pkg::abs_d(n_ex);
            r_aey         <= lscd_pkg::abs_d(n_ey);
            r_asex        <= n_ex[lscd_pkg::CW];
            r_asey        <= n_ey[lscd_pkg::CW];
        end
    end

    // stage B: squares and cross terms
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_bs  <= r_as;
            r_wxx <= r_as.awx * r_as.awx;
            r_wyy <= r_as.awy * r_as.awy;
            r_p1  <= r_aex * r_as.awx;
            r_p2  <= r_aey * r_as.awy;
            r_n1  <= r_asex ^ r_as.swx;
            r_n2  <= r_asey ^ r_as.swy;
        end
    end

    // stage C: squared length and signed dot product as magnitude and sign
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cs <= r_bs;
            r_dd <= {1'b0, r_wxx} + {1'b0, r_wyy};
            if (r_n1 == r_n2) begin
                r_num <= {1'b0, r_p1} + {1'b0, r_p2};
                r_neg <= r_n1;
            end else if (r_p1 >= r_p2) begin
                r_num <= {1'b0, r_p1 - r_p2};
                r_neg <= r_n1;
            end else begin
                r_num <= {1'b0, r_p2 - r_p1};
                r_neg <= r_n2;
            end
        end
    end

    // stage D: decide which point realizes the distance
    always_comb begin
        n_negf   = r_neg && (r_num != '0);
        n_small  = r_dd < (PW+1)'({i_eps, {lscd_pkg::FW{1'b0}}});
        n_beyond = !n_negf && (r_num >= r_dd);
        if (r_cs.is_point || n_small || n_beyond) begin
            n_pick = lscd_pkg::PICK_S1;
        end else if (n_negf) begin
            n_pick = lscd_pkg::PICK_S2;
        end else begin
            n_pick = lscd_pkg::PICK_PROJ;
        end
        n_ds      = r_cs;
        n_ds.pick = n_pick;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ds[0]  <= n_ds;
            r_rem[0] <= r_num;
            r_den[0] <= r_dd;
            r_quo[0] <= '0;
        end
    end

    for (genvar gk = 0; gk < lscd_pkg::FW; gk++) begin : g_div
        logic [PW+1:0] n_sh;
        logic [PW+1:0] n_diff;
        logic          n_ge;

        assign n_sh   = {r_rem[gk], 1'b0};
        assign n_diff = n_sh - {1'b0, r_den[gk]};
        assign n_ge   = (n_sh >= {1'b0, r_den[gk]});

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_rem[gk+1] <= n_ge ? n_diff[PW:0] : n_sh[PW:0];
                r_quo[gk+1] <= {r_quo[gk][lscd_pkg::FW-2:0], n_ge};
                r_den[gk+1] <= r_den[gk];
                r_ds[gk+1]  <= r_ds[gk];
            end
        end
    end

    // stage E: scale the segment by the projection ratio
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_es <= r_ds[lscd_pkg::FW];
            r_mx <= r_ds[lscd_pkg::FW].awx * r_quo[lscd_pkg::FW];
            r_my <= r_ds[lscd_pkg::FW].awy * r_quo[lscd_pkg::FW];
        end
    end

    // stage F: projected point, chosen point, offsets to the query
    always_comb begin
        n_xpx = r_es.swx
              ? lscd_pkg::ext(r_es.s2.x) - {1'b0, r_mx[lscd_pkg::CW+lscd_pkg::FW-1:lscd_pkg::FW]}
              : lscd_pkg::ext(r_es.s2.x) + {1'b0, r_mx[lscd_pkg::CW+lscd_pkg::FW-1:lscd_pkg::FW]};
        n_xpy = r_es.swy
              ? lscd_pkg::ext(r_es.s2.y) - {1'b0, r_my[lscd_pkg::CW+lscd_pkg::FW-1:lscd_pkg::FW]}
              : lscd_pkg::ext(r_es.s2.y) + {1'b0, r_my[lscd_pkg::CW+lscd_pkg::FW-1:lscd_pkg::FW]};
        n_xp.x = n_xpx[lscd_pkg::CW-1:0];
        n_xp.y = n_xpy[lscd_pkg::CW-1:0];
        unique case (r_es.pick)
            lscd_pkg::PICK_S1:   n_pt = r_es.s1;
            lscd_pkg::PICK_S2:   n_pt = r_es.s2;
            lscd_pkg::PICK_PROJ: n_pt = n_xp;
            default:             n_pt = r_es.s1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_fdx   <= lscd_pkg::abs_d(lscd_pkg::ext(r_es.q.x) - lscd_pkg::ext(n_pt.x));
            r_fdy   <= lscd_pkg::abs_d(lscd_pkg::ext(r_es.q.y) - lscd_pkg::ext(n_pt.y));
            r_fhit  <= (r_es.pick != lscd_pkg::PICK_PROJ);
            r_fflat <= r_es.flat;
        end
    end

    // stage G: squares
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dx2   <= r_fdx * r_fdx;
            r_dy2   <= r_fdy * r_fdy;
            r_ghit  <= r_fhit;
            r_gflat <= r_fflat;
        end
    end

    // output register: sum, saturate, override for a flat triangle
    assign n_sum = (lscd_pkg::DIST_W+1)'(r_dx2) + (lscd_pkg::DIST_W+1)'(r_dy2);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (r_gflat) begin
                r_out.dist_sq      <= '0;
                r_out.endpoint_hit <= 1'b0;
                r_out.flat_error   <= 1'b1;
            end else begin
                r_out.dist_sq      <= n_sum[lscd_pkg::DIST_W] ? '1
                                                                : n_sum[lscd_pkg::DIST_W-1:0];
                r_out.endpoint_hit <= r_ghit;
                r_out.flat_error   <= 1'b0;
            end
        end
    end

    // valid bits advance with the shared enable
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < lscd_pkg::XL; i++) begin
                r_xv[i] <= 1'b0;
            end
            for (int i = 0; i <= lscd_pkg::FW; i++) begin
                r_dv[i] <= 1'b0;
            end
            r_av <= 1'b0;
            r_bv <= 1'b0;
            r_cv <= 1'b0;
            r_ev <= 1'b0;
            r_fv <= 1'b0;
            r_gv <= 1'b0;
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_xv[0] <= i_valid;
            for (int i = 1; i < lscd_pkg::XL; i++) begin
                r_xv[i] <= r_xv[i-1];
            end
            r_av  <= r_xv[lscd_pkg::XL-1];
            r_bv  <= r_av;
            r_cv  <= r_bv;
            r_dv[0] <= r_cv;
            for (int i = 1; i <= lscd_pkg::FW; i++) begin
                r_dv[i] <= r_dv[i-1];
            end
            r_ev <= r_dv[lscd_pkg::FW];
            r_fv <= r_ev;
            r_gv <= r_fv;
            r_ov <= r_gv;
        end
    end

    assign o_valid = r_ov;
    assign o_item  = r_out;

endmodule
